@@ rtl/core/msfsd_pkg.sv @@
`default_nettype none
package msfsd_pkg;

    localparam int MAX_MOTORS_DEF = 16;
    localparam int MOTOR_ID_W     = 4;
    localparam int MCNT_W         = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    // item function codes
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_REL  = 2'd1;
    localparam logic [1:0] FUNC_ABS  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOTORS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_BITS    = 2'd1;

    localparam logic [4:0] MOTORS_IN_USE_RST = 5'd16;
    localparam logic [6:0] CHAIN_BITS_RST    = 7'd64;

    typedef struct packed {
        logic [1:0]            func;
        logic [MOTOR_ID_W-1:0] motor;
        logic signed [31:0]    amount;
    } t_in_item;

    typedef struct packed {
        logic [63:0] command_word;
        logic [15:0] finished_mask;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic                  cap_item;
        logic                  clr_acc;
        logic                  rd_en;
        logic                  rd_tick;
        logic [MOTOR_ID_W-1:0] rd_addr;
        logic                  load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic              out_free;
        logic [MCNT_W-1:0] motor_count;
    } t_status;

    // two-phase full-step coil sequence
    function automatic logic [3:0] coil_pattern(input logic [1:0] sel);
        logic [3:0] pat;
        unique case (sel)
            2'd0: pat = 4'b1100;
            2'd1: pat = 4'b0110;
            2'd2: pat = 4'b0011;
            2'd3: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/msfsd_ctrl.sv @@
`default_nettype none
module msfsd_ctrl #(
    parameter int MAX_MOTORS = msfsd_pkg::MAX_MOTORS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  msfsd_pkg::t_in_item  i_in_item,
    input  msfsd_pkg::t_status   i_sts,
    output msfsd_pkg::t_cmd      o_cmd
);
    import msfsd_pkg::*;

    localparam int IDX_W = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_MV_RD    = 3'd1;
    localparam logic [2:0] S_TK_RUN   = 3'd2;
    localparam logic [2:0] S_TK_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             last_motor;

    assign last_motor = ((MCNT_W'(r_cnt) + MCNT_W'(1)) == i_sts.motor_count);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_item = 1'b1;
                    priority if (i_in_item.func == FUNC_TICK) begin
                        o_cmd.clr_acc = 1'b1;
                        n_cnt         = '0;
                        n_state       = (i_sts.motor_count == '0) ? S_DONE : S_TK_RUN;
                    end else if (i_in_item.func == FUNC_REL || i_in_item.func == FUNC_ABS) begin
                        if (MCNT_W'(i_in_item.motor) < MCNT_W'(MAX_MOTORS)) begin
                            n_state = S_MV_RD;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MV_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_IDLE;
            end
            S_TK_RUN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_tick = 1'b1;
                o_cmd.rd_addr = MOTOR_ID_W'(r_cnt);
                n_cnt         = r_cnt + IDX_W'(1);
                if (last_motor) begin
                    n_state = S_TK_DRAIN;
                end
            end
            S_TK_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/msfsd_dp.sv @@
`default_nettype none
module msfsd_dp #(
    parameter int MAX_MOTORS = msfsd_pkg::MAX_MOTORS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  msfsd_pkg::t_in_item                   i_in_item,
    input  wire                                   i_cfg_valid,
    input  wire [msfsd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [msfsd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  msfsd_pkg::t_cmd                       i_cmd,
    output msfsd_pkg::t_status                    o_sts,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output msfsd_pkg::t_out_item                  o_out_item
);
    import msfsd_pkg::*;

    localparam int IDX_W = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;

    // configuration
    logic [4:0] r_motors_in_use;
    logic [6:0] r_chain_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motors_in_use <= MOTORS_IN_USE_RST;
            r_chain_bits    <= CHAIN_BITS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MOTORS_IN_USE: r_motors_in_use <= i_cfg_data[4:0];
                CFG_CHAIN_BITS:    r_chain_bits    <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    assign o_sts.motor_count = (r_motors_in_use > MCNT_W'(MAX_MOTORS)) ?
                               MCNT_W'(MAX_MOTORS) : r_motors_in_use;
    assign o_sts.out_free    = !o_out_valid || i_out_ready;

    // captured item
    t_in_item r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_item) begin
            r_item <= i_cmd.cap_item ? i_in_item : r_item;
        end
    end

    // position / target stores; an unwritten entry reads as zero
    logic [31:0]           r_pos_mem [MAX_MOTORS];
    logic [31:0]           r_tgt_mem [MAX_MOTORS];
    logic [MAX_MOTORS-1:0] r_pos_set, r_tgt_set;
    logic [31:0]           r_pos_rd, r_tgt_rd;
    logic                  r_pos_ok, r_tgt_ok;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_step_v, r_move_v;
    logic [IDX_W-1:0]      rd_idx;

    assign rd_idx = i_cmd.rd_tick ? i_cmd.rd_addr[IDX_W-1:0] : r_item.motor[IDX_W-1:0];

    logic [31:0] pos, tgt, diff, new_pos, new_tgt;
    logic        moving, arrive;

    assign pos     = r_pos_ok ? r_pos_rd : '0;
    assign tgt     = r_tgt_ok ? r_tgt_rd : '0;
    assign diff    = tgt - pos;
    assign moving  = (diff != '0);
    assign arrive  = (diff == 32'd1) || (diff == '1);
    assign new_pos = diff[31] ? (pos - 32'd1) : (pos + 32'd1);
    assign new_tgt = (r_item.func == FUNC_REL) ? (pos + 32'(r_item.amount))
                                               : 32'(r_item.amount);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_pos_rd <= r_pos_mem[rd_idx];
            r_tgt_rd <= r_tgt_mem[rd_idx];
            r_rd_idx <= rd_idx;
        end
        if (r_step_v && moving) begin
            r_pos_mem[r_rd_idx] <= new_pos;
        end
        if (r_move_v) begin
            r_tgt_mem[r_rd_idx] <= new_tgt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_set <= '0;
            r_tgt_set <= '0;
            r_pos_ok  <= 1'b0;
            r_tgt_ok  <= 1'b0;
            r_step_v  <= 1'b0;
            r_move_v  <= 1'b0;
        end else begin
            r_step_v <= i_cmd.rd_en && i_cmd.rd_tick;
            r_move_v <= i_cmd.rd_en && !i_cmd.rd_tick;
            if (i_cmd.rd_en) begin
                r_pos_ok <= r_pos_set[rd_idx];
                r_tgt_ok <= r_tgt_set[rd_idx];
            end
            if (r_step_v && moving) begin
                r_pos_set[r_rd_idx] <= 1'b1;
            end
            if (r_move_v) begin
                r_tgt_set[r_rd_idx] <= 1'b1;
            end
        end
    end

    // nibble placement at chain_bits - 4*(id+1), signed 9 bits
    logic [4:0]  id_p1;
    logic [8:0]  offset, neg_off;
    logic [3:0]  nib;
    logic [63:0] placed;

    assign id_p1   = MCNT_W'(r_rd_idx) + 5'd1;
    assign offset  = {2'b00, r_chain_bits} - {2'b00, id_p1, 2'b00};
    assign neg_off = 9'd0 - offset;
    assign nib     = coil_pattern(new_pos[1:0]);

    always_comb begin
        priority if (offset[8:6] == 3'b000) begin
            placed = 64'(nib) << offset[5:0];
        end else if (offset[8:2] == 7'h7F && offset[1:0] != 2'b00) begin
            placed = 64'(nib >> neg_off[1:0]);
        end else begin
            placed = '0;
        end
    end

    // tick accumulators
    logic [63:0] r_word;
    logic [15:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_word <= '0;
            r_mask <= '0;
        end else if (r_step_v && moving) begin
            r_word <= r_word | placed;
            if (arrive) begin
                r_mask <= r_mask | (16'd1 << r_rd_idx);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_out_item.command_word  <= r_word;
            o_out_item.finished_mask <= r_mask;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/multi_stepper_full_step_driver_core.sv @@
// Full-step sequencer for up to MAX_MOTORS two-phase steppers on one shift chain.
// Input channel (i_in_valid / o_in_ready, i_in_item): a move item sets one motor's
// target, relative to its position or absolute; a tick item steps every motor in
// use one full step toward its target. Func code 3 and moves to a motor at or
// above MAX_MOTORS are dropped quietly.
// Output channel (o_out_valid / i_out_ready, o_out_item): one item per tick, with
// the coil bits for the whole chain and the mask of motors that arrived.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 motors_in_use,
// index 1 chain_bits; write only while the block is idle.
// Sequence: a move reads its motor's entry in S_MV_RD and then returns to idle.
// A tick with n motors in use (motors_in_use clamped to MAX_MOTORS) reads one motor
// per cycle through the single read port of the position/target store, passes
// through the drain state S_TK_DRAIN, loads the result register in S_DONE and
// then takes the next item. With no motors in use it goes from idle straight to
// S_DONE and loads the result there.
// A result waiting in the output register does not block the input side; only a
// tick that finishes while the previous result is still held waits for the
// receiver to take it.
// Reset clears positions and targets to zero (per-entry valid bits), sets
// motors_in_use to 16 and chain_bits to 64, and empties the result register.
`default_nettype none
module multi_stepper_full_step_driver_core #(
    parameter int MAX_MOTORS = msfsd_pkg::MAX_MOTORS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  msfsd_pkg::t_in_item               i_in_item,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output msfsd_pkg::t_out_item              o_out_item,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [msfsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [msfsd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import msfsd_pkg::*;

    t_cmd    cmd;
    t_status sts;

    // config registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    msfsd_ctrl #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    msfsd_dp #(
        .MAX_MOTORS (MAX_MOTORS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire
